[rtl/rcc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and helpers of the repeated character run collapse.
// ---------------------------------------------------------------------------
package rcc_pkg;

  localparam int MAX_THRESHOLD = 16;
  localparam int MAX_RESULTS   = 30;
  localparam int THR_CAP       = (MAX_THRESHOLD < MAX_RESULTS) ? MAX_THRESHOLD : MAX_RESULTS;

  localparam int CHAR_W = 21;
  localparam int THR_W  = 5;
  localparam int CNT_W  = 5;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_KEEP      = 1'b1
  } rcc_reg_t;

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(2);
  localparam logic             KEEP_RST      = 1'b1;

  typedef logic [CHAR_W-1:0] rcc_char_t;
  typedef logic [CNT_W-1:0]  rcc_cnt_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             keep;
  } rcc_cfg_t;

  // one accepted character, resolved into up to two run flushes
  typedef struct packed {
    rcc_char_t a_char;
    rcc_cnt_t  a_cnt;
    rcc_char_t b_char;
    rcc_cnt_t  b_cnt;
    logic      last;
  } rcc_cmd_t;

  function automatic logic [THR_W-1:0] thr_in_use(input logic [THR_W-1:0] t);
    logic [THR_W-1:0] r;
    r = t;
    if (r == '0) r = THR_W'(1);
    if (r > THR_W'(THR_CAP)) r = THR_W'(THR_CAP);
    return r;
  endfunction

  function automatic rcc_cnt_t flush_cnt(input logic [THR_W-1:0] len,
                                         input logic [THR_W-1:0] thr,
                                         input logic             keep);
    rcc_cnt_t r;
    if (len == '0)       r = '0;
    else if (len >= thr) r = CNT_W'(1);
    else if (keep)       r = CNT_W'(len);
    else                 r = '0;
    return r;
  endfunction

endpackage

[rtl/rcc_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcc_in_if / rcc_out_if
// Valid/ready channels for input characters and emitted results.
// ---------------------------------------------------------------------------
interface rcc_in_if;
  import rcc_pkg::*;
  logic      valid;
  logic      ready;
  rcc_char_t in_char;
  logic      text_last;

  modport source (output valid, output in_char, output text_last, input ready);
  modport sink   (input valid, input in_char, input text_last, output ready);
endinterface

interface rcc_out_if;
  import rcc_pkg::*;
  logic      valid;
  logic      ready;
  rcc_char_t out_char;
  logic      has_char;
  logic      burst_last;
  logic      text_end;

  modport source (output valid, output out_char, output has_char, output burst_last,
                  output text_end, input ready);
  modport sink   (input valid, input out_char, input has_char, input burst_last,
                  input text_end, output ready);
endinterface

[rtl/rcc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcc_front
// Accepts characters, tracks the open run and turns each request into a
// flush command for the queue.
// ---------------------------------------------------------------------------
module rcc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rcc_pkg::rcc_cfg_t cfg,
  rcc_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output rcc_pkg::rcc_cmd_t push_cmd
);
  import rcc_pkg::*;

  rcc_char_t        run_char_r, run_char_nxt;
  logic [THR_W-1:0] run_len_r, run_len_nxt;
  logic [THR_W-1:0] thr;
  rcc_char_t        new_char;
  logic [THR_W-1:0] new_len;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign thr         = thr_in_use(cfg.threshold);

  always_comb begin
    push_cmd = '0;
    new_char = run_char_r;
    new_len  = run_len_r;
    priority if (run_len_r == '0) begin
      new_char = in_ch.in_char;
      new_len  = THR_W'(1);
    end else if (in_ch.in_char == run_char_r) begin
      if (run_len_r < thr) new_len = run_len_r + THR_W'(1);
    end else begin
      push_cmd.a_char = run_char_r;
      push_cmd.a_cnt  = flush_cnt(run_len_r, thr, cfg.keep);
      new_char        = in_ch.in_char;
      new_len         = THR_W'(1);
    end
    run_char_nxt = new_char;
    run_len_nxt  = new_len;
    if (in_ch.text_last) begin
      push_cmd.b_char = new_char;
      push_cmd.b_cnt  = flush_cnt(new_len, thr, cfg.keep);
      push_cmd.last   = 1'b1;
      run_char_nxt    = '0;
      run_len_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_char_r <= '0;
      run_len_r  <= '0;
    end else if (push) begin
      run_char_r <= run_char_nxt;
      run_len_r  <= run_len_nxt;
    end
  end

endmodule

[rtl/rcc_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcc_queue
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
module rcc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rcc_pkg::rcc_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output rcc_pkg::rcc_cmd_t q_cmd
);
  import rcc_pkg::*;

  rcc_cmd_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + Q_CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - Q_CNT_W'(1);
    end
  end

endmodule

[rtl/rcc_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcc_back
// Expands queued flush commands into result requests, one per cycle while
// the output is ready, through a registered output stage.
// ---------------------------------------------------------------------------
module rcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  rcc_pkg::rcc_cmd_t q_cmd,
  output logic              pop,
  rcc_out_if.source         out_ch
);
  import rcc_pkg::*;

  logic      cur_valid_r, cur_valid_nxt;
  rcc_cmd_t  cur_r, cur_nxt;
  logic      out_valid_r, out_valid_nxt;
  rcc_char_t out_char_r, out_char_nxt;
  logic      has_char_r, has_char_nxt;
  logic      burst_last_r, burst_last_nxt;
  logic      text_end_r, text_end_nxt;

  logic emit_a, emit_b, emit_m, emit_any, slot_free, advance, final_res, retire;

  assign emit_a    = cur_valid_r && (cur_r.a_cnt != '0);
  assign emit_b    = cur_valid_r && !emit_a && (cur_r.b_cnt != '0);
  assign emit_m    = cur_valid_r && !emit_a && !emit_b && cur_r.last;
  assign emit_any  = emit_a || emit_b || emit_m;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign advance   = cur_valid_r && (!emit_any || slot_free);
  assign final_res = emit_a ? (cur_r.a_cnt == CNT_W'(1)) && (cur_r.b_cnt == '0)
                   : emit_b ? (cur_r.b_cnt == CNT_W'(1))
                   : 1'b1;
  assign retire    = advance && final_res;
  assign pop       = q_valid && (!cur_valid_r || retire);

  always_comb begin
    cur_valid_nxt  = cur_valid_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    has_char_nxt   = has_char_r;
    burst_last_nxt = burst_last_r;
    text_end_nxt   = text_end_r;

    if (advance) begin
      if (emit_a)      cur_nxt.a_cnt = cur_r.a_cnt - CNT_W'(1);
      else if (emit_b) cur_nxt.b_cnt = cur_r.b_cnt - CNT_W'(1);
    end
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_cmd;
    end else if (retire) begin
      cur_valid_nxt = 1'b0;
    end

    if (slot_free) begin
      out_valid_nxt  = advance && emit_any;
      out_char_nxt   = emit_a ? cur_r.a_char : (emit_b ? cur_r.b_char : '0);
      has_char_nxt   = emit_a || emit_b;
      burst_last_nxt = final_res;
      text_end_nxt   = final_res && cur_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_char_r   <= out_char_nxt;
    has_char_r   <= has_char_nxt;
    burst_last_r <= burst_last_nxt;
    text_end_r   <= text_end_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_char   = out_char_r;
  assign out_ch.has_char   = has_char_r;
  assign out_ch.burst_last = burst_last_r;
  assign out_ch.text_end   = text_end_r;

endmodule

[rtl/repeated_char_run_collapse.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// repeated_char_run_collapse
// Path: first result of a request passes the queue, the command register
// and the output register. Throughput: one result per cycle while out_ch is
// ready; a 2-entry command queue decouples intake.
// Reset: synchronous active-low; clears run state, queue and output valid,
// threshold resets to 2 and keep to 1.
// ---------------------------------------------------------------------------
module repeated_char_run_collapse (
  input  logic                                clk,
  input  logic                                rst_n,
  rcc_in_if.sink                              in_ch,
  rcc_out_if.source                           out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rcc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rcc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import rcc_pkg::*;

  rcc_cfg_t cfg_r, cfg_nxt;
  rcc_reg_t reg_sel;
  logic     cfg_wr;
  logic     push, q_full, pop, q_valid;
  rcc_cmd_t push_cmd, q_cmd;

  assign pready  = 1'b1;
  assign reg_sel = rcc_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_THRESHOLD: cfg_nxt.threshold = pwdata[THR_W-1:0];
        REG_KEEP:      cfg_nxt.keep      = pwdata[0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.threshold);
      REG_KEEP:      prdata = CFG_DATA_W'(cfg_r.keep);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.keep      <= KEEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  rcc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // empty end marker carries no character and closes both burst and text
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.has_char) |->
      (out_ch.out_char == '0) && out_ch.burst_last && out_ch.text_end)
    else $error("end marker malformed");

  a_text_end_closes_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.text_end) |-> out_ch.burst_last)
    else $error("text_end without burst_last");

  a_cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (reg_sel == REG_THRESHOLD)) |=>
      (cfg_r.threshold == $past(pwdata[THR_W-1:0])))
    else $error("threshold write lost");

  a_in_ready_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !q_full)
    else $error("intake ready disagrees with queue level");

endmodule

[sim/repeated_char_run_collapse_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// repeated_char_run_collapse_tb
// Self-checking bench for the run collapse block. Drives texts made of runs
// of repeated characters under several threshold and keep settings, predicts
// every emitted result and compares the output stream in order.
// ---------------------------------------------------------------------------
module repeated_char_run_collapse_tb;
  import rcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    rcc_char_t ch;
    logic      has_char;
    logic      burst_last;
    logic      text_end;
  } emitted_t;

  class run_scoreboard;
    logic [THR_W-1:0] threshold;
    logic             keep;
    rcc_char_t        run_ch;
    logic [THR_W-1:0] run_len;
    emitted_t         burst[$];
    emitted_t         expected[$];
    int               errors;

    function new();
      threshold = THR_W'(2);
      keep      = 1'b1;
      run_ch    = '0;
      run_len   = '0;
      errors    = 0;
    endfunction

    function void write_reg(rcc_reg_t r, logic [31:0] v);
      case (r)
        REG_THRESHOLD: threshold = v[THR_W-1:0];
        REG_KEEP:      keep = v[0];
        default: ;
      endcase
    endfunction

    function logic [THR_W-1:0] effective_threshold();
      int t;
      t = int'(threshold);
      if (t == 0) t = 1;
      if (t > MAX_THRESHOLD) t = MAX_THRESHOLD;
      if (t > MAX_RESULTS) t = MAX_RESULTS;
      return THR_W'(t);
    endfunction

    function void push_char(rcc_char_t c, logic has);
      emitted_t e;
      e = '{ch: c, has_char: has, burst_last: 1'b0, text_end: 1'b0};
      burst.push_back(e);
    endfunction

    function void judge_run(logic [THR_W-1:0] thr);
      if (run_len == '0) return;
      if (run_len >= thr) begin
        push_char(run_ch, 1'b1);
      end else if (keep) begin
        for (int i = 0; i < int'(run_len); i++) push_char(run_ch, 1'b1);
      end
    endfunction

    function void note_request(rcc_char_t c, logic last);
      logic [THR_W-1:0] thr;
      thr = effective_threshold();
      burst.delete();
      if (run_len == '0) begin
        run_ch  = c;
        run_len = THR_W'(1);
      end else if (c == run_ch) begin
        if (run_len < thr) run_len++;
      end else begin
        judge_run(thr);
        run_ch  = c;
        run_len = THR_W'(1);
      end
      if (last) begin
        judge_run(thr);
        run_ch  = '0;
        run_len = '0;
        if (burst.size() == 0) push_char('0, 1'b0);
      end
      if (burst.size() > 0) begin
        burst[burst.size()-1].burst_last = 1'b1;
        if (last) burst[burst.size()-1].text_end = 1'b1;
      end
      foreach (burst[i]) expected.push_back(burst[i]);
    endfunction

    function int pending();
      return expected.size();
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_result(emitted_t got);
      emitted_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result char=%06h has=%0b", got.ch, got.has_char));
        return;
      end
      want = expected.pop_front();
      if (got.ch !== want.ch)
        report($sformatf("out_char %06h, want %06h", got.ch, want.ch));
      if (got.has_char !== want.has_char)
        report($sformatf("has_char %0b, want %0b", got.has_char, want.has_char));
      if (got.burst_last !== want.burst_last)
        report($sformatf("burst_last %0b, want %0b (char %06h)", got.burst_last,
                         want.burst_last, want.ch));
      if (got.text_end !== want.text_end)
        report($sformatf("text_end %0b, want %0b (char %06h)", got.text_end,
                         want.text_end, want.ch));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  wire  [CFG_DATA_W-1:0] prdata;
  wire                   pready;

  rcc_in_if  in_if();
  rcc_out_if out_if();

  run_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int n_items = 0;

  repeated_char_run_collapse DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check, then pick next ready
  initial begin
    emitted_t got;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = '{ch: out_if.out_char, has_char: out_if.has_char,
                burst_last: out_if.burst_last, text_end: out_if.text_end};
        sb.check_result(got);
      end
      out_if.ready <= !gaps_on || ($urandom_range(99) >= 29);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("repeated_char_run_collapse regression: fail");
        $finish;
      end
    end
  end

  task automatic send_req(rcc_char_t c, logic last);
    while (gaps_on && $urandom_range(99) < 29) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_char   <= c;
    in_if.text_last <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(c, last);
    n_items++;
  endtask

  task automatic cfg_write(rcc_reg_t r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(r, v);
  endtask

  // drain all results, then allow zero-result requests to retire
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic rcc_char_t pick_char();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return rcc_char_t'(97 + $urandom_range(3));
      6, 7:             return rcc_char_t'($urandom_range(0, 1114111));
      8:                return rcc_char_t'($urandom);
      default:          return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_text(int runs, bit close);
    rcc_char_t ch;
    int len;
    for (int r = 0; r < runs; r++) begin
      ch  = pick_char();
      len = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(1, 20);
      for (int k = 0; k < len; k++)
        send_req(ch, close && (r == runs - 1) && (k == len - 1));
    end
  endtask

  task automatic run_phase(int thr, bit keep, int count, bit gaps);
    int target;
    settle();
    cfg_write(REG_THRESHOLD, 32'(thr));
    cfg_write(REG_KEEP, 32'(keep));
    gaps_on = gaps;
    target = n_items + count;
    while (n_items < target) begin
      if ($urandom_range(9) < 8)
        send_text($urandom_range(1, 6), 1'b1);
      else
        repeat ($urandom_range(1, 6)) send_req(pick_char(), $urandom_range(3) == 0);
    end
    // sometimes leave a run open across the next setting change
    if ($urandom_range(1)) send_text(1, 1'b0);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.in_char   = '0;
    in_if.text_last = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: threshold 2, keep on
    send_req('0, 1'b1);
    send_req(21'h1FFFFF, 1'b0);
    send_req(21'h1FFFFF, 1'b1);
    send_req(21'h10FFFF, 1'b0);
    send_req(21'h0AAAAA, 1'b0);
    send_req(21'h155555, 1'b1);

    // threshold zero acts as one
    settle();
    cfg_write(REG_THRESHOLD, 32'd0);
    cfg_write(REG_KEEP, 32'd0);
    send_req(21'd7, 1'b0);
    send_req(21'd8, 1'b1);

    // all runs dropped: empty end marker
    settle();
    cfg_write(REG_THRESHOLD, 32'd3);
    send_req(21'd9, 1'b0);
    send_req(21'd10, 1'b1);

    // oversized threshold, short run kept in full
    settle();
    cfg_write(REG_THRESHOLD, 32'd31);
    cfg_write(REG_KEEP, 32'd1);
    repeat (2) send_req(21'd6, 1'b0);
    send_req(21'd6, 1'b1);

    // threshold raised mid-run: saturated count replayed
    settle();
    cfg_write(REG_THRESHOLD, 32'd2);
    repeat (3) send_req(21'd11, 1'b0);
    settle();
    cfg_write(REG_THRESHOLD, 32'd5);
    send_req(21'd12, 1'b1);

    run_phase(1, 1'b1, 35, 1'b1);
    run_phase(16, 1'b0, 35, 1'b1);
    run_phase(2, 1'b1, 45, 1'b0);
    run_phase(31, 1'b1, 35, 1'b1);
    run_phase(0, 1'b1, 30, 1'b1);
    run_phase(3, 1'b0, 35, 1'b1);
    repeat (4) run_phase($urandom_range(0, 31), $urandom_range(1), 30, 1'b1);

    gaps_on = 1'b1;
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("repeated_char_run_collapse regression: pass");
    else
      $display("repeated_char_run_collapse regression: fail");
    $finish;
  end

endmodule

[repeated_char_run_collapse.f]
rtl/rcc_pkg.sv
rtl/rcc_if.sv
rtl/rcc_front.sv
rtl/rcc_queue.sv
rtl/rcc_back.sv
rtl/repeated_char_run_collapse.sv
sim/repeated_char_run_collapse_tb.sv
